// File: src/hal_pkg.sv
// ----------------------------------------------------------------------------
// hal_pkg
// Shared constants, types and elaboration helpers for the Halton generator.
// ----------------------------------------------------------------------------
package hal_pkg;

  // Default configuration of the generator.
  localparam int unsigned HAL_SAMPLES_PER_RUN = 8;
  localparam int unsigned HAL_INDEX_BITS      = 20;
  localparam int unsigned HAL_FRAC_BITS       = 24;

  // Fixed field widths of the channels.
  localparam int unsigned HAL_START_W = 20;
  localparam int unsigned HAL_SLOT_W  = 3;
  localparam int unsigned HAL_COORD_W = 24;

  // The four dimensions and their radix.
  localparam int unsigned HAL_NUM_BASES = 4;
  localparam int unsigned HAL_BASES [HAL_NUM_BASES] = '{2, 3, 5, 7};

  // Operating mode of one lane of the conversion chain.
  typedef enum logic {
    HAL_MODE_INT,
    HAL_MODE_FRAC
  } hal_mode_t;

  // Control that travels alongside each point through the chain.
  typedef struct packed {
    logic                  valid;
    logic [HAL_SLOT_W-1:0] slot;
    logic                  last;
  } hal_tag_t;

  // Number of base-b digits needed to hold any value below 2^idx_bits.
  function automatic int unsigned hal_ndig(input int unsigned base,
                                           input int unsigned idx_bits);
    longint unsigned lim;
    longint unsigned p;
    int unsigned     k;
    lim = (64'd1 << idx_bits) - 64'd1;
    p   = 64'd1;
    k   = 0;
    for (int i = 0; i < 64; i++) begin
      if (p <= lim) begin
        p = p * longint'(base);
        k = k + 1;
      end
    end
    return k;
  endfunction

endpackage

// File: src/halton_4d_sample_generator.sv
// ----------------------------------------------------------------------------
// halton_4d_sample_generator
// Emits runs of four-dimensional Halton points (bases 2, 3, 5, 7) as
// truncated fixed-point fractions.
// ----------------------------------------------------------------------------
// Usage: each transfer on the input channel carries a start offset. The block
// answers with SAMPLES_PER_RUN result transfers, one per sequence index from
// the offset upward (wrapping modulo 2^INDEX_BITS), in order. Every result
// carries the slot within the run, the four radical inverses as unsigned
// fractions and a flag on the final point of the run.
// Throughput: one result per cycle while the receiver does not stall; the
// next start offset is taken in the cycle the last index of the current
// run enters the chain. The cell chain spends one cell per index bit on
// binary to base-b conversion and one cell per fraction bit on the
// division by b^K.
// Reset clears the sequencer and all valid bits; no result is pending after.
// When the receiver stalls a held point, the whole chain holds, the output
// register keeps its payload, and the input side stalls as well.
// ----------------------------------------------------------------------------
module halton_4d_sample_generator #(
  parameter int unsigned SAMPLES_PER_RUN = hal_pkg::HAL_SAMPLES_PER_RUN,
  parameter int unsigned INDEX_BITS      = hal_pkg::HAL_INDEX_BITS,
  parameter int unsigned FRAC_BITS       = hal_pkg::HAL_FRAC_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [hal_pkg::HAL_START_W-1:0] in_start_offset,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [hal_pkg::HAL_SLOT_W-1:0]  out_sample_slot,
  output logic [hal_pkg::HAL_COORD_W-1:0] out_coord_base2,
  output logic [hal_pkg::HAL_COORD_W-1:0] out_coord_base3,
  output logic [hal_pkg::HAL_COORD_W-1:0] out_coord_base5,
  output logic [hal_pkg::HAL_COORD_W-1:0] out_coord_base7,
  output logic                            out_run_last
);

  import hal_pkg::*;

  // One cell per index bit, then one cell per fraction bit.
  localparam int unsigned NStage = INDEX_BITS + FRAC_BITS;

  logic                  adv;
  hal_tag_t              issue;
  logic [INDEX_BITS-1:0] issue_idx;
  hal_tag_t              tag_r [NStage];
  logic [INDEX_BITS-1:0] idx_r [INDEX_BITS-1];
  logic                  stage_cin [NStage];
  logic [FRAC_BITS-1:0]  coord_q [HAL_NUM_BASES];

  // The chain moves as a whole whenever the output register is free or is
  // being emptied by a transfer in this cycle.
  assign adv = !tag_r[NStage-1].valid || !out_stall;

  hal_seq #(
    .SAMPLES_PER_RUN (SAMPLES_PER_RUN),
    .INDEX_BITS      (INDEX_BITS)
  ) u_seq (
    .clk               (clk),
    .rst_n             (rst_n),
    .adv_i             (adv),
    .in_valid_i        (in_valid),
    .in_start_offset_i (in_start_offset),
    .in_stall_o        (in_stall),
    .issue_o           (issue),
    .issue_idx_o       (issue_idx)
  );

  // Control tags follow the points through every cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NStage; k++) begin
        tag_r[k] <= '0;
      end
    end else if (adv) begin
      tag_r[0] <= issue;
      for (int k = 1; k < NStage; k++) begin
        tag_r[k] <= tag_r[k-1];
      end
    end
  end

  // The index is shifted out most significant bit first, one bit per
  // conversion cell, so each cell sees its bit at the top of its copy.
  always_ff @(posedge clk) begin
    if (adv) begin
      idx_r[0] <= issue_idx << 1;
      for (int k = 1; k < INDEX_BITS - 1; k++) begin
        idx_r[k] <= idx_r[k-1] << 1;
      end
    end
  end

  // Carry into each cell: the next index bit during conversion, and zero
  // during the division, where the doubling brings in no new digit.
  for (genvar k = 0; k < NStage; k++) begin : g_cin
    if (k == 0) begin : g_first
      assign stage_cin[k] = issue_idx[INDEX_BITS-1];
    end else if (k < INDEX_BITS) begin : g_conv
      assign stage_cin[k] = idx_r[k-1][INDEX_BITS-1];
    end else begin : g_div
      assign stage_cin[k] = 1'b0;
    end
  end

  // One row of cells per radix. The first INDEX_BITS cells build the index
  // in base b by repeated doubling. Between the two halves the digit order
  // is reversed, which turns the index into the numerator R of R / b^K.
  // Each following cell doubles R; the carry out of the top digit says
  // whether 2R reached b^K, which is one bit of the long division.
  for (genvar b = 0; b < HAL_NUM_BASES; b++) begin : g_base
    localparam int unsigned Base = HAL_BASES[b];
    localparam int unsigned NDig = hal_ndig(Base, INDEX_BITS);
    localparam int unsigned DigW = $clog2(Base);

    logic [NDig*DigW-1:0] dig  [NStage];
    logic [NDig*DigW-1:0] din  [NStage];
    logic [FRAC_BITS-1:0] q    [NStage];
    logic [FRAC_BITS-1:0] qin  [NStage];
    logic [NDig*DigW-1:0] dig_rev;

    for (genvar j = 0; j < NDig; j++) begin : g_rev
      assign dig_rev[j*DigW +: DigW] = dig[INDEX_BITS-1][(NDig-1-j)*DigW +: DigW];
    end

    for (genvar k = 0; k < NStage; k++) begin : g_stage
      if (k == 0) begin : g_head
        assign din[k] = '0;
        assign qin[k] = '0;
      end else if (k < INDEX_BITS) begin : g_conv
        assign din[k] = dig[k-1];
        assign qin[k] = '0;
      end else if (k == INDEX_BITS) begin : g_turn
        assign din[k] = dig_rev;
        assign qin[k] = '0;
      end else begin : g_div
        assign din[k] = dig[k-1];
        assign qin[k] = q[k-1];
      end

      hal_lane #(
        .BASE      (Base),
        .NDIG      (NDig),
        .FRAC_BITS (FRAC_BITS),
        .MODE      ((k < INDEX_BITS) ? HAL_MODE_INT : HAL_MODE_FRAC)
      ) u_lane (
        .clk   (clk),
        .adv_i (adv),
        .dig_i (din[k]),
        .cin_i (stage_cin[k]),
        .q_i   (qin[k]),
        .dig_o (dig[k]),
        .q_o   (q[k])
      );
    end

    assign coord_q[b] = q[NStage-1];
  end

  // The last cell of the chain is the output register.
  assign out_valid       = tag_r[NStage-1].valid;
  assign out_sample_slot = tag_r[NStage-1].slot;
  assign out_run_last    = tag_r[NStage-1].last;
  assign out_coord_base2 = HAL_COORD_W'(coord_q[0]);
  assign out_coord_base3 = HAL_COORD_W'(coord_q[1]);
  assign out_coord_base5 = HAL_COORD_W'(coord_q[2]);
  assign out_coord_base7 = HAL_COORD_W'(coord_q[3]);

endmodule

// File: src/hal_lane.sv
// ----------------------------------------------------------------------------
// hal_lane
// One cell of the conversion chain for one radix: doubles a base-b digit
// vector and shifts in a carry, registering the result.
// ----------------------------------------------------------------------------
module hal_lane #(
  parameter int unsigned       BASE      = 2,
  parameter int unsigned       NDIG      = 20,
  parameter int unsigned       FRAC_BITS = 24,
  parameter hal_pkg::hal_mode_t MODE     = hal_pkg::HAL_MODE_INT
) (
  input  logic                          clk,
  input  logic                          adv_i,
  input  logic [NDIG*$clog2(BASE)-1:0]  dig_i,
  input  logic                          cin_i,
  input  logic [FRAC_BITS-1:0]          q_i,
  output logic [NDIG*$clog2(BASE)-1:0]  dig_o,
  output logic [FRAC_BITS-1:0]          q_o
);

  import hal_pkg::*;

  localparam int unsigned DigW = $clog2(BASE);

  logic [NDIG*DigW-1:0] dig_nxt;
  logic [NDIG*DigW-1:0] dig_r;
  logic                 carry;

  // Each digit becomes 2*d + carry_in, reduced by the base when it overflows.
  // The carry ripples from the lowest digit upward like an adder carry chain.
  always_comb begin : p_double
    logic          c;
    logic [DigW:0] v;
    c       = cin_i;
    dig_nxt = '0;
    for (int j = 0; j < NDIG; j++) begin
      v = {dig_i[j*DigW +: DigW], c};
      if (v >= (DigW+1)'(BASE)) begin
        dig_nxt[j*DigW +: DigW] = DigW'(v - (DigW+1)'(BASE));
        c = 1'b1;
      end else begin
        dig_nxt[j*DigW +: DigW] = DigW'(v);
        c = 1'b0;
      end
    end
    carry = c;
  end

  always_ff @(posedge clk) begin
    if (adv_i) begin
      dig_r <= dig_nxt;
    end
  end

  assign dig_o = dig_r;

  // In fraction mode the carry out of the top digit is the next quotient bit.
  if (MODE == HAL_MODE_FRAC) begin : g_frac
    logic [FRAC_BITS-1:0] q_r;
    always_ff @(posedge clk) begin
      if (adv_i) begin
        q_r <= {q_i[FRAC_BITS-2:0], carry};
      end
    end
    assign q_o = q_r;
  end else begin : g_int
    assign q_o = '0;
  end

endmodule

// File: src/hal_seq.sv
// ----------------------------------------------------------------------------
// hal_seq
// Run sequencer: takes a start offset and issues one sequence index per
// cycle for every point of the run while the chain advances.
// ----------------------------------------------------------------------------
module hal_seq #(
  parameter int unsigned SAMPLES_PER_RUN = hal_pkg::HAL_SAMPLES_PER_RUN,
  parameter int unsigned INDEX_BITS      = hal_pkg::HAL_INDEX_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv_i,
  input  logic                           in_valid_i,
  input  logic [hal_pkg::HAL_START_W-1:0] in_start_offset_i,
  output logic                           in_stall_o,
  output hal_pkg::hal_tag_t              issue_o,
  output logic [INDEX_BITS-1:0]          issue_idx_o
);

  import hal_pkg::*;

  localparam int unsigned CntW = (SAMPLES_PER_RUN > 1) ? $clog2(SAMPLES_PER_RUN) : 1;

  logic                  active_r, active_nxt;
  logic [CntW-1:0]       cnt_r, cnt_nxt;
  logic [INDEX_BITS-1:0] start_r, start_nxt;
  logic                  at_last;
  logic                  take;

  assign at_last    = (cnt_r == CntW'(SAMPLES_PER_RUN - 1));
  // A new run may start in the cycle the last point of the current one issues.
  assign in_stall_o = !adv_i || (active_r && !at_last);
  assign take       = in_valid_i && !in_stall_o;

  always_comb begin
    active_nxt = active_r;
    cnt_nxt    = cnt_r;
    start_nxt  = start_r;
    if (take) begin
      active_nxt = 1'b1;
      cnt_nxt    = '0;
      start_nxt  = INDEX_BITS'(in_start_offset_i);
    end else if (adv_i && active_r) begin
      if (at_last) begin
        active_nxt = 1'b0;
        cnt_nxt    = '0;
      end else begin
        cnt_nxt = cnt_r + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      active_r <= active_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    start_r <= start_nxt;
  end

  always_comb begin
    issue_o.valid = active_r;
    issue_o.slot  = HAL_SLOT_W'(cnt_r);
    issue_o.last  = at_last;
    issue_idx_o   = start_r + INDEX_BITS'(cnt_r);
  end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the four-dimensional Halton point generator.
// Start offsets go in on the input channel. Every point of every run is
// compared with an exact radical-inverse calculation done here. Both channels
// idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hal_pkg::*;

  // One expected point of a run, held at the widths of the result ports.
  typedef struct packed {
    logic [HAL_SLOT_W-1:0]  slot;
    logic [HAL_COORD_W-1:0] c2;
    logic [HAL_COORD_W-1:0] c3;
    logic [HAL_COORD_W-1:0] c5;
    logic [HAL_COORD_W-1:0] c7;
    logic                   last;
  } halton_point_t;

  // One stimulus row. A pinned row carries the coordinates of its first point
  // typed in by hand. Those values are used for slot 0 in place of the
  // calculated ones.
  typedef struct packed {
    logic [HAL_START_W-1:0] offs;
    logic                   pinned;
    logic [HAL_COORD_W-1:0] c2;
    logic [HAL_COORD_W-1:0] c3;
    logic [HAL_COORD_W-1:0] c5;
    logic [HAL_COORD_W-1:0] c7;
  } start_row_t;

  localparam int unsigned RANDOM_RUNS  = 452;
  localparam int unsigned CHAIN_CYCLES = HAL_INDEX_BITS + HAL_FRAC_BITS;

  logic                   clk             = 1'b0;
  logic                   rst_n           = 1'b0;
  logic                   in_valid        = 1'b0;
  logic                   in_stall;
  logic [HAL_START_W-1:0] in_start_offset = '0;
  logic                   out_valid;
  logic                   out_stall       = 1'b0;
  logic [HAL_SLOT_W-1:0]  out_sample_slot;
  logic [HAL_COORD_W-1:0] out_coord_base2;
  logic [HAL_COORD_W-1:0] out_coord_base3;
  logic [HAL_COORD_W-1:0] out_coord_base5;
  logic [HAL_COORD_W-1:0] out_coord_base7;
  logic                   out_run_last;

  // Points still owed by the block, oldest first.
  halton_point_t points_due[$];
  // Row currently offered on the input channel. It is set at the falling edge
  // together with the port, so it is stable at the next rising edge.
  start_row_t    cur_row = '0;
  // While set, neither side idles. This gives a stretch at full rate.
  bit            calm = 1'b0;
  int unsigned   mismatches    = 0;
  int unsigned   runs_taken    = 0;
  int unsigned   points_seen   = 0;
  int unsigned   wrapped_runs  = 0;

  halton_4d_sample_generator #(
    .SAMPLES_PER_RUN (HAL_SAMPLES_PER_RUN),
    .INDEX_BITS      (HAL_INDEX_BITS),
    .FRAC_BITS       (HAL_FRAC_BITS)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_start_offset (in_start_offset),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_sample_slot (out_sample_slot),
    .out_coord_base2 (out_coord_base2),
    .out_coord_base3 (out_coord_base3),
    .out_coord_base5 (out_coord_base5),
    .out_coord_base7 (out_coord_base7),
    .out_run_last    (out_run_last)
  );

  // 12 ns period.
  always #6 clk = ~clk;

  // Exact radical inverse of idx in the given radix, as a Q0.FRAC_BITS
  // fraction cut to the coordinate width. The digits are reversed into
  // num / den. The fraction bits then come out of a restoring binary long
  // division, one bit per step. The largest denominator is 7^8, so 64 bits
  // leave plenty of headroom.
  function automatic logic [HAL_COORD_W-1:0] radical_inverse_q(
    input longint unsigned idx,
    input int unsigned     radix
  );
    longint unsigned n;
    longint unsigned num;
    longint unsigned den;
    longint unsigned q;
    longint unsigned rdx;
    rdx = 64'(radix);
    n   = idx;
    num = 64'd0;
    den = 64'd1;
    q   = 64'd0;
    while (n != 64'd0) begin
      num = num * rdx + (n % rdx);
      n   = n / rdx;
      den = den * rdx;
    end
    for (int k = 0; k < HAL_FRAC_BITS; k++) begin
      num = num << 1;
      q   = q << 1;
      if (num >= den) begin
        num = num - den;
        q   = q | 64'd1;
      end
    end
    return q[HAL_COORD_W-1:0];
  endfunction

  // Queues every point that one accepted start offset owes. The sequence
  // index wraps modulo 2^INDEX_BITS. The slot wraps at the port width.
  function automatic void enqueue_run_points(input start_row_t row);
    longint unsigned idx_mask;
    longint unsigned idx;
    halton_point_t   pt;
    idx_mask = (64'd1 << HAL_INDEX_BITS) - 64'd1;
    if (longint'(row.offs) + longint'(HAL_SAMPLES_PER_RUN) - 64'd1 > idx_mask)
      wrapped_runs++;
    for (int s = 0; s < HAL_SAMPLES_PER_RUN; s++) begin
      idx     = (longint'(row.offs) + longint'(s)) & idx_mask;
      pt.slot = s[HAL_SLOT_W-1:0];
      pt.c2   = radical_inverse_q(idx, HAL_BASES[0]);
      pt.c3   = radical_inverse_q(idx, HAL_BASES[1]);
      pt.c5   = radical_inverse_q(idx, HAL_BASES[2]);
      pt.c7   = radical_inverse_q(idx, HAL_BASES[3]);
      pt.last = (s == HAL_SAMPLES_PER_RUN - 1);
      if (s == 0 && row.pinned) begin
        pt.c2 = row.c2;
        pt.c3 = row.c3;
        pt.c5 = row.c5;
        pt.c7 = row.c7;
      end
      points_due.push_back(pt);
    end
  endfunction

  function automatic void compare_field(input string field,
                                        input logic [HAL_COORD_W-1:0] want,
                                        input logic [HAL_COORD_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
      mismatches++;
    end
  endfunction

  // Scoreboard. The result side is checked first, then a start offset
  // transferred at this edge adds its points. Both happen in one process,
  // so the order within the time step is fixed.
  always @(posedge clk) begin
    halton_point_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (points_due.size() == 0) begin
          $error("result transfer with nothing expected: slot %0d", out_sample_slot);
          mismatches++;
        end else begin
          want = points_due.pop_front();
          compare_field("sample_slot", HAL_COORD_W'(want.slot),
                        HAL_COORD_W'(out_sample_slot));
          compare_field("coord_base2", want.c2, out_coord_base2);
          compare_field("coord_base3", want.c3, out_coord_base3);
          compare_field("coord_base5", want.c5, out_coord_base5);
          compare_field("coord_base7", want.c7, out_coord_base7);
          compare_field("run_last", HAL_COORD_W'(want.last),
                        HAL_COORD_W'(out_run_last));
          points_seen++;
        end
      end
      if (in_valid && !in_stall) begin
        enqueue_run_points(cur_row);
        runs_taken++;
      end
    end
  end

  // The receiver stalls at random with a probability of 18 percent, except while calm is set.
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 18);
  end

  // Offers one start offset and returns at the falling edge after its
  // transfer. Valid is lowered only when an idle gap follows. Back-to-back
  // offers therefore keep it high, and it gets one assignment per time step.
  task automatic send_run(input start_row_t row);
    int unsigned gap;
    gap = 0;
    while (!calm && $urandom_range(99) < 18)
      gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cur_row          = row;
    in_valid        <= 1'b1;
    in_start_offset <= row.offs;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Directed start offsets. The origin is all zeros. Index one is one half,
  // one third, one fifth and one seventh truncated to 24 bits. Both are
  // pinned by hand. The other rows cover the top of the index range, runs
  // that wrap through zero, alternating bit patterns and runs that step
  // across a power of each base, where the digit count grows.
  start_row_t directed[] = '{
    '{20'h00000, 1'b1, 24'h000000, 24'h000000, 24'h000000, 24'h000000},
    '{20'h00001, 1'b1, 24'h800000, 24'h555555, 24'h333333, 24'h249249},
    '{20'hFFFFF, 1'b0, 24'h0, 24'h0, 24'h0, 24'h0},
    '{20'hFFFF9, 1'b0, 24'h0, 24'h0, 24'h0, 24'h0},
    '{20'h80000, 1'b0, 24'h0, 24'h0, 24'h0, 24'h0},
    '{20'h7FFFC, 1'b0, 24'h0, 24'h0, 24'h0, 24'h0},
    '{20'hAAAAA, 1'b0, 24'h0, 24'h0, 24'h0, 24'h0},
    '{20'h55555, 1'b0, 24'h0, 24'h0, 24'h0, 24'h0},
    '{20'd531437, 1'b0, 24'h0, 24'h0, 24'h0, 24'h0},
    '{20'd531441, 1'b0, 24'h0, 24'h0, 24'h0, 24'h0},
    '{20'd390620, 1'b0, 24'h0, 24'h0, 24'h0, 24'h0},
    '{20'd390625, 1'b0, 24'h0, 24'h0, 24'h0, 24'h0},
    '{20'd823540, 1'b0, 24'h0, 24'h0, 24'h0, 24'h0},
    '{20'd823543, 1'b0, 24'h0, 24'h0, 24'h0, 24'h0},
    '{20'd117645, 1'b0, 24'h0, 24'h0, 24'h0, 24'h0},
    '{20'd45,     1'b0, 24'h0, 24'h0, 24'h0, 24'h0},
    '{20'd22,     1'b0, 24'h0, 24'h0, 24'h0, 24'h0},
    '{20'd8,      1'b0, 24'h0, 24'h0, 24'h0, 24'h0},
    '{20'hFFFF0, 1'b0, 24'h0, 24'h0, 24'h0, 24'h0}
  };

  initial begin : stimulus
    start_row_t      row;
    longint unsigned pw;
    longint unsigned radix;
    int unsigned     steps;

    // Hold reset low from the start and release it at a falling edge.
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[i])
      send_run(directed[i]);

    // Random offsets. One quarter each: anywhere in the range, just below
    // the wrap point, small indices, and near a power of one of the bases.
    // A stretch in the middle runs with no idling on either side.
    for (int unsigned r = 0; r < RANDOM_RUNS; r++) begin
      calm = (r >= 150 && r < 250);
      row  = '0;
      case ($urandom_range(3))
        0: begin
          row.offs = HAL_START_W'($urandom());
        end
        1: begin
          row.offs = HAL_START_W'(32'hFFFFF - $urandom_range(15));
        end
        2: begin
          row.offs = HAL_START_W'($urandom_range(255));
        end
        default: begin
          radix = 64'(HAL_BASES[$urandom_range(HAL_NUM_BASES - 1)]);
          steps = $urandom_range(1, 19);
          pw    = radix;
          repeat (steps)
            if (pw * radix < (64'd1 << HAL_INDEX_BITS))
              pw = pw * radix;
          row.offs = HAL_START_W'(pw - 64'($urandom_range(7)));
        end
      endcase
      send_run(row);
    end
    calm      = 1'b0;
    in_valid <= 1'b0;

    // Drain. Then wait out the chain length once more, so that a stray extra
    // result would still be caught.
    while (points_due.size() != 0)
      @(posedge clk);
    repeat (CHAIN_CYCLES + 16) @(posedge clk);

    $display("Covered %0d runs and %0d checked points; %0d runs wrapped the index.",
             runs_taken, points_seen, wrapped_runs);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches found.", mismatches);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog. 2 ms leaves a wide margin over a correct run even with long
  // stall bursts.
  initial begin : watchdog
    #2_000_000;
    $display("Timeout with %0d points still expected.", points_due.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
